@@ rtl/core/ptc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptc_pkg - shared types and constants
// Widths, register indexes, coefficient and queue word layouts used by the
// compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RAW_W       = 20;
    localparam int TFINE_W     = 32;
    localparam int TC_W        = 16;
    localparam int PRES_W      = 32;
    localparam int COEF_W      = 16;
    localparam int DIV_W       = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int TEMP_REG_W  = 48;
    localparam int BACK_PRE    = 6;
    localparam int BACK_LAT    = BACK_PRE + DIV_W + 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP  = 2'd0,
        REG_PLOW  = 2'd1,
        REG_PHIGH = 2'd2,
        REG_PLAST = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [COEF_W-1:0] t1;
        logic [COEF_W-1:0] t2;
        logic [COEF_W-1:0] t3;
        logic [COEF_W-1:0] p1;
        logic [COEF_W-1:0] p2;
        logic [COEF_W-1:0] p3;
        logic [COEF_W-1:0] p4;
        logic [COEF_W-1:0] p5;
        logic [COEF_W-1:0] p6;
        logic [COEF_W-1:0] p7;
        logic [COEF_W-1:0] p8;
        logic [COEF_W-1:0] p9;
    } coeff_t;

    typedef struct packed {
        logic [RAW_W-1:0]          adc_p;
        logic signed [TFINE_W-1:0] tfine;
        logic signed [TC_W-1:0]    tc;
    } item_t;

endpackage

@@ rtl/core/pressure_temp_compensation.sv @@
// ----------------------------------------------------------------------------
// pressure_temp_compensation - barometric sensor integer compensation
// Turns raw 20-bit temperature and pressure readings into compensated
// temperature and Q24.8 pressure using twelve calibration coefficients.
//
// Input stream s_axis carries one raw pair per word; output stream m_axis
// carries one compensated result per input word, in order.
// Coefficients are loaded through cfg_we/cfg_index/cfg_data; the user
// must load them only while idle, the block does not enforce it.
// One word is accepted every cycle while s_axis_tready is high; the
// accepting edge loads the first of four temperature stages, and the
// word then passes the queue, six pressure stages, a 64-stage divider
// (one quotient bit per stage), four final stages and the output register.
// Reset clears all coefficients to zero and empties the pipeline.
// When m_axis_tvalid is high and m_axis_tready is low, the output word
// holds, the pressure pipeline freezes, the queue fills and s_axis_tready
// then drops. A zero divisor gives pressure_valid low and pressure zero.
// ----------------------------------------------------------------------------
module pressure_temp_compensation #(
    parameter int QUEUE_DEPTH = ptc_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // raw_temperature[19:0], raw_pressure[39:20]
    input  logic [ptc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // temperature_centi[15:0], fine_temperature[47:16], pressure_q24_8[79:48]
    output logic [ptc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // pressure_valid[0]
    output logic                            m_axis_tuser,
    input  logic                            cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ptc_pkg::*;

    logic [TEMP_REG_W-1:0] temp_reg;
    logic [CFG_DATA_W-1:0] plow_reg;
    logic [CFG_DATA_W-1:0] phigh_reg;
    logic [COEF_W-1:0]     plast_reg;
    coeff_t                coeff;

    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_empty;
    item_t                 q_in;
    item_t                 q_out;

    logic [TC_W-1:0]       out_tc;
    logic [TFINE_W-1:0]    out_tfine;
    logic [PRES_W-1:0]     out_pres;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg  <= '0;
            plow_reg  <= '0;
            phigh_reg <= '0;
            plast_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TEMP:  temp_reg  <= cfg_data[TEMP_REG_W-1:0];
                REG_PLOW:  plow_reg  <= cfg_data;
                REG_PHIGH: phigh_reg <= cfg_data;
                REG_PLAST: plast_reg <= cfg_data[COEF_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        coeff.t1 = temp_reg[15:0];
        coeff.t2 = temp_reg[31:16];
        coeff.t3 = temp_reg[47:32];
        coeff.p1 = plow_reg[15:0];
        coeff.p2 = plow_reg[31:16];
        coeff.p3 = plow_reg[47:32];
        coeff.p4 = plow_reg[63:48];
        coeff.p5 = phigh_reg[15:0];
        coeff.p6 = phigh_reg[31:16];
        coeff.p7 = phigh_reg[47:32];
        coeff.p8 = phigh_reg[63:48];
        coeff.p9 = plast_reg;
    end

    ptc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .raw_t    (s_axis_tdata[19:0]),
        .raw_p    (s_axis_tdata[39:20]),
        .coeff    (coeff),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in)
    );

    ptc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    ptc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .coeff      (coeff),
        .q_empty    (q_empty),
        .q_item     (q_out),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_tc     (out_tc),
        .out_tfine  (out_tfine),
        .out_pres   (out_pres),
        .out_pvalid (m_axis_tuser)
    );

    assign m_axis_tdata = {out_pres, out_tfine, out_tc};

endmodule

@@ rtl/core/ptc_fifo.sv @@
// ----------------------------------------------------------------------------
// ptc_fifo - queue between temperature front and pressure back
// Small register queue holding compensated temperature words until the
// pressure pipeline takes them.
// ----------------------------------------------------------------------------
module ptc_fifo #(
    parameter int DEPTH = ptc_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ptc_pkg::item_t din,
    output logic           full,
    input  logic           pop,
    output ptc_pkg::item_t dout,
    output logic           empty
);
    import ptc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    item_t            mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/ptc_front.sv @@
// ----------------------------------------------------------------------------
// ptc_front - input side and temperature compensation
// Accepts raw sample pairs, computes fine and centi-degree temperature over
// four stages and pushes the word into the queue.
// ----------------------------------------------------------------------------
module ptc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [ptc_pkg::RAW_W-1:0]  raw_t,
    input  logic [ptc_pkg::RAW_W-1:0]  raw_p,
    input  ptc_pkg::coeff_t            coeff,
    input  logic                       q_full,
    output logic                       q_push,
    output ptc_pkg::item_t             q_item
);
    import ptc_pkg::*;

    logic [3:0]               fv_reg;
    logic                     adv;

    logic signed [33:0]       f1_ma_reg;
    logic signed [33:0]       f1_dd_reg;
    logic [RAW_W-1:0]         f1_p_reg;
    logic signed [22:0]       f2_v1_reg;
    logic signed [38:0]       f2_mv2_reg;
    logic [RAW_W-1:0]         f2_p_reg;
    logic signed [TFINE_W-1:0] f3_tf_reg;
    logic [RAW_W-1:0]         f3_p_reg;
    item_t                    f4_item_reg;

    logic signed [17:0]       a_s;
    logic signed [16:0]       d_s;
    logic signed [33:0]       ma;
    logic signed [33:0]       dd;
    logic signed [38:0]       mv2;
    logic signed [24:0]       v2;
    logic signed [TFINE_W-1:0] tf;
    logic signed [35:0]       t5;
    logic signed [27:0]       tcw;
    logic signed [TC_W-1:0]   tc;

    assign adv      = !fv_reg[3] || !q_full;
    assign in_ready = adv;
    assign q_push   = fv_reg[3] && !q_full;
    assign q_item   = f4_item_reg;

    always_comb
    begin
        a_s = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, coeff.t1, 1'b0});
        d_s = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, coeff.t1});
        ma  = a_s * $signed(coeff.t2);
        dd  = d_s * d_s;
        mv2 = $signed({1'b0, f1_dd_reg[33:12]}) * $signed(coeff.t3);
        v2  = 25'(f2_mv2_reg >>> 14);
        tf  = TFINE_W'(f2_v1_reg) + TFINE_W'(v2);
        t5  = (36'(f3_tf_reg) <<< 2) + 36'(f3_tf_reg) + 36'sd128;
        tcw = 28'(t5 >>> 8);
        if (tcw < -28'sd32768)
        begin
            tc = -16'sd32768;
        end
        else if (tcw > 28'sd32767)
        begin
            tc = 16'sd32767;
        end
        else
        begin
            tc = tcw[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (adv)
        begin
            fv_reg <= {fv_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_ma_reg         <= ma;
            f1_dd_reg         <= dd;
            f1_p_reg          <= raw_p;
            f2_v1_reg         <= 23'(f1_ma_reg >>> 11);
            f2_mv2_reg        <= mv2;
            f2_p_reg          <= f1_p_reg;
            f3_tf_reg         <= tf;
            f3_p_reg          <= f2_p_reg;
            f4_item_reg.adc_p <= f3_p_reg;
            f4_item_reg.tfine <= f3_tf_reg;
            f4_item_reg.tc    <= tc;
        end
    end

endmodule

@@ rtl/core/ptc_div.sv @@
// ----------------------------------------------------------------------------
// ptc_div - pipelined unsigned divider
// One quotient bit per stage, restoring, a new word may enter every cycle while en is high.
// ----------------------------------------------------------------------------
module ptc_div (
    input  logic                      clk,
    input  logic                      en,
    input  logic [ptc_pkg::DIV_W-1:0] num,
    input  logic [ptc_pkg::DIV_W-1:0] den,
    output logic [ptc_pkg::DIV_W-1:0] quo
);
    import ptc_pkg::*;

    logic [DIV_W-1:0] r_reg  [0:DIV_W-1];
    logic [DIV_W-1:0] nq_reg [0:DIV_W-1];
    logic [DIV_W-1:0] d_reg  [0:DIV_W-1];

    genvar g;
    generate
        for (g = 0; g < DIV_W; g++)
        begin : g_stage
            logic [DIV_W-1:0] rp;
            logic [DIV_W-1:0] nqp;
            logic [DIV_W-1:0] dp;
            logic [DIV_W:0]   sh;
            logic [DIV_W:0]   diff;
            logic             ge;

            if (g == 0)
            begin : g_first
                assign rp  = '0;
                assign nqp = num;
                assign dp  = den;
            end
            else
            begin : g_next
                assign rp  = r_reg[g-1];
                assign nqp = nq_reg[g-1];
                assign dp  = d_reg[g-1];
            end

            always_comb
            begin
                sh   = {rp, nqp[DIV_W-1]};
                diff = sh - {1'b0, dp};
                ge   = (sh >= {1'b0, dp});
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[g]  <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
                    nq_reg[g] <= {nqp[DIV_W-2:0], ge};
                    d_reg[g]  <= dp;
                end
            end
        end
    endgenerate

    assign quo = nq_reg[DIV_W-1];

endmodule

@@ rtl/core/ptc_back.sv @@
// ----------------------------------------------------------------------------
// ptc_back - pressure compensation pipeline
// Takes queued words, runs the 64-bit pressure polynomial and division,
// saturates and drives the output register.
// ----------------------------------------------------------------------------
module ptc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ptc_pkg::coeff_t             coeff,
    input  logic                        q_empty,
    input  ptc_pkg::item_t              q_item,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ptc_pkg::TC_W-1:0]    out_tc,
    output logic [ptc_pkg::TFINE_W-1:0] out_tfine,
    output logic [ptc_pkg::PRES_W-1:0]  out_pres,
    output logic                        out_pvalid
);
    import ptc_pkg::*;

    localparam logic [63:0] BIAS_47 = 64'h0000_8000_0000_0000;
    localparam logic [11:0] MUL_3125 = 12'd3125;

    typedef struct packed {
        logic signed [TC_W-1:0]    tc;
        logic signed [TFINE_W-1:0] tfine;
        logic                      neg;
        logic                      zero;
    } side_t;

    logic [BACK_LAT-1:0] vld_reg;
    side_t               side_reg [0:BACK_LAT-1];
    logic                adv;

    logic [63:0]         b1_sq_reg;
    logic signed [49:0]  b1_x1p5_reg;
    logic signed [49:0]  b1_x1p2_reg;
    logic [RAW_W-1:0]    b1_adcp_reg;
    logic [63:0]         b2_sqp6_reg;
    logic [63:0]         b2_sqp3_reg;
    logic signed [49:0]  b2_x1p5_reg;
    logic signed [49:0]  b2_x1p2_reg;
    logic [RAW_W-1:0]    b2_adcp_reg;
    logic [63:0]         b3_x2_reg;
    logic [63:0]         b3_xb_reg;
    logic [RAW_W-1:0]    b3_adcp_reg;
    logic [63:0]         b4_prod_reg;
    logic [63:0]         b4_num_reg;
    logic [63:0]         b5_den_reg;
    logic [63:0]         b5_num_reg;
    logic [63:0]         b6_nmag_reg;
    logic [63:0]         b6_dmag_reg;
    logic [63:0]         b7_p_reg;
    logic [63:0]         e1_m_reg;
    logic [63:0]         e1_q_reg;
    logic [63:0]         e1_y2p_reg;
    logic [63:0]         e1_p_reg;
    logic [63:0]         e2_ll_reg;
    logic [31:0]         e2_cross_reg;
    logic [63:0]         e2_y2_reg;
    logic [63:0]         e2_p_reg;
    logic [63:0]         e3_sum_reg;

    logic                out_valid_reg;
    logic [TC_W-1:0]     out_tc_reg;
    logic [TFINE_W-1:0]  out_tfine_reg;
    logic [PRES_W-1:0]   out_pres_reg;
    logic                out_pvalid_reg;

    logic signed [33:0]  x1;
    logic signed [67:0]  sq_full;
    logic signed [49:0]  x1p5;
    logic signed [49:0]  x1p2;
    logic signed [79:0]  sqp6_full;
    logic signed [79:0]  sqp3_full;
    logic [63:0]         x2;
    logic [63:0]         xb;
    logic signed [80:0]  prod_full;
    logic [20:0]         pdiff;
    logic [63:0]         num_pre;
    logic [75:0]         num_full;
    logic [63:0]         quo;
    logic [63:0]         qq;
    logic signed [79:0]  m_full;
    logic signed [79:0]  y2p_full;
    logic [63:0]         ll;
    logic [63:0]         lh;
    logic [63:0]         hl;
    logic [63:0]         mm;
    logic [63:0]         y1;
    logic [63:0]         pr;
    logic [PRES_W-1:0]   pres;
    side_t               side_in;
    side_t               side_b6;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && !q_empty;

    always_comb
    begin
        x1        = $signed({{2{q_item.tfine[31]}}, q_item.tfine}) - 34'sd128000;
        sq_full   = x1 * x1;
        x1p5      = x1 * $signed(coeff.p5);
        x1p2      = x1 * $signed(coeff.p2);
        sqp6_full = $signed(b1_sq_reg) * $signed(coeff.p6);
        sqp3_full = $signed(b1_sq_reg) * $signed(coeff.p3);
        x2        = b2_sqp6_reg
                  + ({{14{b2_x1p5_reg[49]}}, b2_x1p5_reg} << 17)
                  + ({{48{coeff.p4[15]}}, coeff.p4} << 35);
        xb        = {{8{b2_sqp3_reg[63]}}, b2_sqp3_reg[63:8]}
                  + ({{14{b2_x1p2_reg[49]}}, b2_x1p2_reg} << 12)
                  + BIAS_47;
        prod_full = $signed(b3_xb_reg) * $signed({1'b0, coeff.p1});
        pdiff     = 21'h100000 - {1'b0, b3_adcp_reg};
        num_pre   = ({43'b0, pdiff} << 31) - b3_x2_reg;
        num_full  = b4_num_reg * MUL_3125;
        qq        = {{13{b7_p_reg[63]}}, b7_p_reg[63:13]};
        m_full    = $signed(coeff.p9) * $signed(qq);
        y2p_full  = $signed(b7_p_reg) * $signed(coeff.p8);
        ll        = e1_m_reg[31:0] * e1_q_reg[31:0];
        lh        = e1_m_reg[31:0] * e1_q_reg[63:32];
        hl        = e1_m_reg[63:32] * e1_q_reg[31:0];
        mm        = e2_ll_reg + {e2_cross_reg, 32'b0};
        y1        = {{25{mm[63]}}, mm[63:25]};
        pr        = {{8{e3_sum_reg[63]}}, e3_sum_reg[63:8]}
                  + ({{48{coeff.p7[15]}}, coeff.p7} << 4);
        if (pr[63])
        begin
            pres = '0;
        end
        else if (|pr[62:32])
        begin
            pres = '1;
        end
        else
        begin
            pres = pr[31:0];
        end
        side_in.tc    = q_item.tc;
        side_in.tfine = q_item.tfine;
        side_in.neg   = 1'b0;
        side_in.zero  = 1'b0;
        side_b6       = side_reg[BACK_PRE-2];
        side_b6.neg   = b5_num_reg[63] ^ b5_den_reg[63];
        side_b6.zero  = (b5_den_reg == '0);
    end

    ptc_div u_div (
        .clk (clk),
        .en  (adv),
        .num (b6_nmag_reg),
        .den (b6_dmag_reg),
        .quo (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[BACK_LAT-2:0], q_pop};
            out_valid_reg <= vld_reg[BACK_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < BACK_LAT; i++)
            begin
                if (i == 0)
                begin
                    side_reg[i] <= side_in;
                end
                else if (i == BACK_PRE - 1)
                begin
                    side_reg[i] <= side_b6;
                end
                else
                begin
                    side_reg[i] <= side_reg[(i > 0) ? i - 1 : 0];
                end
            end
            b1_sq_reg    <= sq_full[63:0];
            b1_x1p5_reg  <= x1p5;
            b1_x1p2_reg  <= x1p2;
            b1_adcp_reg  <= q_item.adc_p;
            b2_sqp6_reg  <= sqp6_full[63:0];
            b2_sqp3_reg  <= sqp3_full[63:0];
            b2_x1p5_reg  <= b1_x1p5_reg;
            b2_x1p2_reg  <= b1_x1p2_reg;
            b2_adcp_reg  <= b1_adcp_reg;
            b3_x2_reg    <= x2;
            b3_xb_reg    <= xb;
            b3_adcp_reg  <= b2_adcp_reg;
            b4_prod_reg  <= prod_full[63:0];
            b4_num_reg   <= num_pre;
            b5_den_reg   <= {{33{b4_prod_reg[63]}}, b4_prod_reg[63:33]};
            b5_num_reg   <= num_full[63:0];
            b6_nmag_reg  <= b5_num_reg[63] ? 64'd0 - b5_num_reg : b5_num_reg;
            b6_dmag_reg  <= b5_den_reg[63] ? 64'd0 - b5_den_reg : b5_den_reg;
            b7_p_reg     <= side_reg[BACK_LAT-5].neg ? 64'd0 - quo : quo;
            e1_m_reg     <= m_full[63:0];
            e1_q_reg     <= qq;
            e1_y2p_reg   <= y2p_full[63:0];
            e1_p_reg     <= b7_p_reg;
            e2_ll_reg    <= ll;
            e2_cross_reg <= lh[31:0] + hl[31:0];
            e2_y2_reg    <= {{19{e1_y2p_reg[63]}}, e1_y2p_reg[63:19]};
            e2_p_reg     <= e1_p_reg;
            e3_sum_reg   <= e2_p_reg + y1 + e2_y2_reg;
            out_tc_reg     <= side_reg[BACK_LAT-1].tc;
            out_tfine_reg  <= side_reg[BACK_LAT-1].tfine;
            out_pvalid_reg <= !side_reg[BACK_LAT-1].zero;
            out_pres_reg   <= side_reg[BACK_LAT-1].zero ? '0 : pres;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_tc     = out_tc_reg;
    assign out_tfine  = out_tfine_reg;
    assign out_pres   = out_pres_reg;
    assign out_pvalid = out_pvalid_reg;

    ap_zero_pres: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_pvalid_reg |-> out_pres_reg == '0)
        else $error("pressure word not cleared on zero divisor");

    ap_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    ap_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");

endmodule
